// ===== hdl/arm64_load_store_decoder_assert.svh =====
// Assertion macros shared by the decoder's checker.
// Depends on nothing; included by the checker file.
`ifndef ARM64_LOAD_STORE_DECODER_ASSERT_SVH
`define ARM64_LOAD_STORE_DECODER_ASSERT_SVH
`define LSD_ASSERT_IMP(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define LSD_ASSERT_NXT(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// ===== hdl/lsd_pkg.sv =====
// Shared types and constants of the load/store decoder.
// Depends on nothing.
`default_nettype none
package lsd_pkg;
  localparam int unsigned InWidth = 32;
  localparam int unsigned OutWidth = 88;
  localparam int unsigned QueueDepth = 2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_UNALLOC = 2'd1;
  localparam logic [1:0] ST_UNPRED = 2'd2;
  localparam logic [1:0] ST_UNSUP = 2'd3;

  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_CAS = 4'd1;
  localparam logic [3:0] OP_CASP = 4'd2;
  localparam logic [3:0] OP_ORDERED = 4'd3;
  localparam logic [3:0] OP_EXCL = 4'd4;
  localparam logic [3:0] OP_PRFM_LIT = 4'd5;
  localparam logic [3:0] OP_LDR_LIT = 4'd6;
  localparam logic [3:0] OP_UNKNOWN = 4'd7;
  localparam logic [3:0] OP_RCPC = 4'd8;
  localparam logic [3:0] OP_PAIR = 4'd9;
  localparam logic [3:0] OP_ATOMIC = 4'd10;
  localparam logic [3:0] OP_LDAPR = 4'd11;
  localparam logic [3:0] OP_PRFM = 4'd12;
  localparam logic [3:0] OP_RPRFM = 4'd13;
  localparam logic [3:0] OP_SINGLE = 4'd14;

  localparam logic [3:0] AM_BASE = 4'd0;
  localparam logic [3:0] AM_LIT = 4'd1;
  localparam logic [3:0] AM_UNSCALED = 4'd2;
  localparam logic [3:0] AM_NONTEMP = 4'd3;
  localparam logic [3:0] AM_POST = 4'd4;
  localparam logic [3:0] AM_PRE = 4'd5;
  localparam logic [3:0] AM_UNSIGNED = 4'd6;
  localparam logic [3:0] AM_REG = 4'd7;
  localparam logic [3:0] AM_UNPRIV = 4'd8;

  localparam logic [2:0] FAM_OTHER = 3'd0;
  localparam logic [2:0] FAM_EXCL = 3'd1;
  localparam logic [2:0] FAM_LIT = 3'd2;
  localparam logic [2:0] FAM_RCPC = 3'd3;
  localparam logic [2:0] FAM_PAIR = 3'd4;
  localparam logic [2:0] FAM_SINGLE = 3'd5;
  localparam logic [2:0] FAM_UNSUP = 3'd6;

  typedef struct packed {
    logic [2:0] family;
    logic [31:0] word;
  } lsd_item_t;

  typedef struct packed {
    logic [1:0] acc;
    logic [1:0] kind;
    logic [2:0] ord;
    logic [1:0] ext;
    logic [1:0] xfer;
  } lsd_attr_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] opcode;
    logic [3:0] atop;
    lsd_attr_t attr;
    logic [4:0] bytes;
    logic [7:0] width;
    logic [3:0] amode;
    logic [20:0] off;
    logic [2:0] extend;
    logic [2:0] shift;
    logic [4:0] rt;
    logic [4:0] rn;
    logic [4:0] rt2;
    logic [4:0] rsm;
  } lsd_result_t;

  function automatic logic [2:0] order_of(input logic acq, input logic rel);
    order_of = acq ? (rel ? 3'd3 : 3'd1) : (rel ? 3'd2 : 3'd0);
  endfunction
endpackage
`default_nettype wire

// ===== hdl/lsd_front.sv =====
// Front end: accepts instruction words and classifies the family from bits 29:24.
// Depends on lsd_pkg.
`default_nettype none
module lsd_front
  import lsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_word,
  output logic             q_valid,
  input  wire logic        q_ready,
  output lsd_item_t        q_item
);
  lsd_item_t item_next;

  always_comb begin
    item_next.word = in_word;
    case (in_word[29:24])
      6'h08: item_next.family = FAM_EXCL;
      6'h18, 6'h1C: item_next.family = FAM_LIT;
      6'h19, 6'h1D: item_next.family = FAM_RCPC;
      6'h28, 6'h29, 6'h2C, 6'h2D: item_next.family = FAM_PAIR;
      6'h38, 6'h39, 6'h3C, 6'h3D: item_next.family = FAM_SINGLE;
      6'h09, 6'h0C, 6'h0D: item_next.family = FAM_UNSUP;
      default: item_next.family = FAM_OTHER;
    endcase
  end

  assign in_ready = !q_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      q_item <= item_next;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/lsd_queue.sv =====
// Short FIFO between the front and back ends.
// Depends on lsd_pkg.
`default_nettype none
module lsd_queue
  import lsd_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  lsd_item_t in_item,
  output logic      out_valid,
  input  wire logic out_ready,
  output lsd_item_t out_item
);
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
  lsd_item_t slots [Depth];
  logic [Aw-1:0] wptr, rptr;
  logic [Aw:0] count;
  logic push, pop;

  assign in_ready = count != (Aw+1)'(Depth);
  assign out_valid = count != '0;
  assign out_item = slots[rptr];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == Aw'(Depth - 1)) ? '0 : wptr + Aw'(1);
      end
      if (pop) begin
        rptr <= (rptr == Aw'(Depth - 1)) ? '0 : rptr + Aw'(1);
      end
      count <= count + (Aw+1)'(push) - (Aw+1)'(pop);
    end
    if (push) begin
      slots[wptr] <= in_item;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/lsd_back.sv =====
// Back end: decodes a classified item and registers the result.
// Depends on lsd_pkg.
`default_nettype none
module lsd_back
  import lsd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  lsd_item_t  in_item,
  output logic       out_valid,
  input  wire logic  out_ready,
  output lsd_result_t out_result
);
  lsd_result_t d;
  logic [1:0] st;
  lsd_result_t res_next;

  function automatic logic [20:0] sx9(input logic [8:0] v);
    sx9 = {{12{v[8]}}, v};
  endfunction

  function automatic logic [7:0] w3264(input logic [4:0] b);
    w3264 = (b == 5'd8) ? 8'd64 : 8'd32;
  endfunction

  always_comb begin
    logic [31:0] w;
    logic [1:0] size, opc, mode;
    logic [4:0] rt, rn, rs, rt2;
    logic fp, pf, load, pair, ordered, ar, ok;
    logic [2:0] form, e;
    logic [3:0] a;
    logic [11:0] imm12;
    logic [23:0] scaled;
    w = in_item.word;
    size = w[31:30];
    rt = w[4:0];
    rn = w[9:5];
    rs = w[20:16];
    rt2 = w[14:10];
    fp = w[26];
    d = '0;
    st = ST_OK;
    pf = 1'b0;
    load = 1'b0;
    pair = 1'b0;
    ordered = 1'b0;
    ar = 1'b0;
    ok = 1'b1;
    form = 3'd0;
    e = 3'd0;
    a = 4'd0;
    opc = 2'd0;
    mode = 2'd0;
    imm12 = 12'd0;
    scaled = 24'd0;
    case (in_item.family)
      FAM_EXCL: begin
        if ((w & 32'h00A07C00) == 32'h00A07C00) begin
          d.opcode = OP_CAS;
          d.attr.acc = 2'd3;
          d.attr.kind = 2'd1;
          d.attr.ord = order_of(w[22], w[15]);
          d.attr.ext = 2'd1;
          d.attr.xfer = 2'd1;
          d.rt = rt;
          d.rn = rn;
          d.rsm = rs;
          d.bytes = 5'd1 << size;
          d.width = w3264(5'd1 << size);
        end else if ((w & 32'h00A07C00) == 32'h00207C00 && !size[1]) begin
          if ((w[24:21] != 4'd1 && w[24:21] != 4'd3) || rs[0] || rt[0]) begin
            st = ST_UNALLOC;
          end else begin
            d.opcode = OP_CASP;
            d.attr.acc = 2'd3;
            d.attr.kind = 2'd1;
            d.attr.ord = order_of(w[22], w[15]);
            d.attr.ext = 2'd1;
            d.attr.xfer = 2'd2;
            d.rt = rt;
            d.rn = rn;
            d.rsm = rs;
            d.bytes = size[0] ? 5'd8 : 5'd4;
            d.width = size[0] ? 8'd64 : 8'd32;
          end
        end else begin
          ordered = w[23];
          load = w[22];
          pair = w[21];
          ar = w[15];
          if (ordered) begin
            if (pair || rs != 5'd31 || rt2 != 5'd31) st = ST_UNALLOC;
          end else if ((pair && !size[1]) || (!pair && rt2 != 5'd31)
                       || (load && rs != 5'd31)) begin
            st = ST_UNALLOC;
          end
          if (st == ST_OK) begin
            d.opcode = ordered ? OP_ORDERED : OP_EXCL;
            d.attr.acc = load ? 2'd1 : 2'd2;
            d.attr.kind = 2'd1;
            if (ordered && !ar) d.attr.ord = load ? 3'd4 : 3'd5;
            else d.attr.ord = order_of(ar && load, ar && !load);
            d.attr.ext = load ? 2'd1 : 2'd0;
            d.attr.xfer = pair ? 2'd2 : 2'd1;
            d.rt = rt;
            d.rn = rn;
            d.rt2 = pair ? rt2 : 5'd0;
            d.rsm = (!ordered && !load) ? rs : 5'd0;
            d.bytes = 5'd1 << size;
            d.width = w3264(5'd1 << size);
            if (pair && load && rt == rt2) st = ST_UNPRED;
            else if (!load && rs != 5'd31 && (rs == rt || (pair && rs == rt2)
                     || (rn != 5'd31 && rs == rn))) st = ST_UNPRED;
          end
        end
      end
      FAM_LIT: begin
        pf = !fp && size == 2'd3;
        d.opcode = pf ? OP_PRFM_LIT : OP_LDR_LIT;
        d.rt = rt;
        if (!pf) begin
          d.attr.acc = 2'd1;
          d.attr.xfer = 2'd1;
          d.attr.kind = fp ? 2'd2 : 2'd1;
        end
        case (size)
          2'd0: d.bytes = 5'd4;
          2'd1: d.bytes = 5'd8;
          2'd2: d.bytes = fp ? 5'd16 : 5'd4;
          default: d.bytes = 5'd0;
        endcase
        d.amode = AM_LIT;
        d.off = {w[23:5], 2'b00};
        if (!fp && !pf) d.attr.ext = (size == 2'd2) ? 2'd2 : 2'd1;
        if (pf) d.width = 8'd0;
        else if (fp) d.width = {d.bytes, 3'b000};
        else d.width = (size == 2'd0) ? 8'd32 : 8'd64;
        if (fp && size == 2'd3) st = ST_UNALLOC;
      end
      FAM_RCPC: begin
        d.opcode = OP_UNKNOWN;
        st = ST_UNSUP;
        if ((w & 32'hBF20FC00) == 32'h19200800) begin
          st = ST_UNSUP;
        end else if ((w & 32'hBF20FC00) == 32'h19200C00) begin
          st = (rs[0] | rt[0]) ? ST_UNALLOC : ST_UNSUP;
        end else if ((w & 32'hBF20FC00) == 32'h19209000
                     || (w & 32'hBF20FC00) == 32'h1920A000
                     || (w & 32'hBF20FC00) == 32'h1920B000) begin
          if (rt == 5'd31 || rs == 5'd31) st = ST_UNALLOC;
          else st = (rt == rs) ? ST_UNPRED : ST_UNSUP;
        end else if ((w & 32'h3F200C00) == 32'h19000000) begin
          opc = w[23:22];
          if ((size == 2'd3 && opc[1]) || (size == 2'd2 && opc == 2'd3)) begin
            st = ST_UNALLOC;
          end else begin
            st = ST_OK;
            d.opcode = OP_RCPC;
            d.rt = rt;
            d.rn = rn;
            d.attr.acc = (opc != 2'd0) ? 2'd1 : 2'd2;
            d.attr.kind = 2'd1;
            d.attr.ord = (opc != 2'd0) ? 3'd1 : 3'd2;
            d.attr.ext = (opc == 2'd0) ? 2'd0 : (opc[1] ? 2'd2 : 2'd1);
            d.attr.xfer = 2'd1;
            d.bytes = 5'd1 << size;
            d.amode = AM_UNSCALED;
            d.off = sx9(w[20:12]);
            d.width = (size == 2'd3 || opc == 2'd2) ? 8'd64 : 8'd32;
          end
        end
      end
      FAM_PAIR: begin
        mode = w[24:23];
        load = w[22];
        d.opcode = OP_PAIR;
        d.rt = rt;
        d.rn = rn;
        d.rt2 = rt2;
        d.attr.kind = fp ? 2'd2 : 2'd1;
        d.attr.acc = load ? 2'd1 : 2'd2;
        d.attr.xfer = 2'd2;
        if (fp) begin
          if (size == 2'd3) begin
            st = ST_UNALLOC;
          end else begin
            d.bytes = 5'd4 << size;
            d.width = {5'd4 << size, 3'b000};
          end
        end else if (size == 2'd3 || (size == 2'd1 && mode == 2'd0)) begin
          st = ST_UNALLOC;
        end else if (size == 2'd1 && !load) begin
          st = ST_UNSUP;
        end else begin
          d.bytes = (size == 2'd2) ? 5'd8 : 5'd4;
          d.width = (size == 2'd0) ? 8'd32 : 8'd64;
          if (load) d.attr.ext = (size == 2'd1) ? 2'd2 : 2'd1;
        end
        if (st == ST_OK) begin
          if (!fp && mode[0] && rn != 5'd31 && (rn == rt || rn == rt2)) begin
            st = ST_UNPRED;
          end else if (load && rt == rt2) begin
            st = ST_UNPRED;
          end else begin
            case (d.bytes)
              5'd4: d.off = {{12{w[21]}}, w[21:15], 2'b0};
              5'd8: d.off = {{11{w[21]}}, w[21:15], 3'b0};
              default: d.off = {{10{w[21]}}, w[21:15], 4'b0};
            endcase
            case (mode)
              2'd0: d.amode = AM_NONTEMP;
              2'd1: d.amode = AM_POST;
              2'd3: d.amode = AM_PRE;
              default: d.amode = AM_BASE;
            endcase
          end
        end
      end
      FAM_SINGLE: begin
        mode = w[11:10];
        opc = w[23:22];
        a = w[15:12];
        if (w[24]) form = 3'd0;
        else if (!w[21]) form = 3'd1;
        else if (mode == 2'd2) form = 3'd2;
        else if (fp) ok = 1'b0;
        else if (mode == 2'd0) form = 3'd4;
        else if (size == 2'd3) form = 3'd3;
        else ok = 1'b0;
        if (!ok) begin
          st = ST_UNALLOC;
        end else if (form == 3'd3) begin
          d.opcode = OP_UNKNOWN;
          st = ST_UNSUP;
        end else if (form == 3'd4) begin
          if (a <= 4'd8) begin
            d.opcode = OP_ATOMIC;
            d.atop = a;
            d.attr.acc = 2'd3;
            d.attr.kind = 2'd1;
            d.attr.ord = order_of(w[23], w[22]);
            d.attr.ext = 2'd1;
            d.attr.xfer = 2'd1;
            d.rt = rt;
            d.rn = rn;
            d.rsm = rs;
            d.bytes = 5'd1 << size;
            d.width = w3264(5'd1 << size);
          end else if (a == 4'd12 && (w & 32'h3FFFFC00) == 32'h38BFC000) begin
            d.opcode = OP_LDAPR;
            d.attr.acc = 2'd1;
            d.attr.kind = 2'd1;
            d.attr.ord = 3'd1;
            d.attr.ext = 2'd1;
            d.attr.xfer = 2'd1;
            d.rt = rt;
            d.rn = rn;
            d.bytes = 5'd1 << size;
            d.width = w3264(5'd1 << size);
          end else if ((a == 4'd9 && (w & 32'hBF20FC00) == 32'h38209000)
                       || (a == 4'd10 && (w & 32'hBF20FC00) == 32'h3820A000)
                       || (a == 4'd11 && (w & 32'hBF20FC00) == 32'h3820B000)) begin
            d.opcode = OP_UNKNOWN;
            st = ST_UNSUP;
          end else if ((a == 4'd9 && w[31:10] == 22'h3E0FE4)
                       || (a == 4'd10 && (w & 32'hFFE0FC00) == 32'hF820A000)
                       || (a == 4'd11 && (w & 32'hFFE0FC00) == 32'hF820B000)
                       || (a == 4'd13 && (w & 32'hFFFFFC00) == 32'hF83FD000)) begin
            if (rt >= 5'd24 || rt[0]) begin
              st = ST_UNALLOC;
            end else begin
              d.opcode = OP_UNKNOWN;
              st = ST_UNSUP;
            end
          end else begin
            st = ST_UNALLOC;
          end
        end else begin
          pf = !fp && size == 2'd3 && opc == 2'd2;
          if (pf && form == 3'd2 && w[4:3] == 2'b11) begin
            d.opcode = OP_RPRFM;
            st = ST_UNSUP;
          end else begin
            if (pf) begin
              d.opcode = OP_PRFM;
              d.rn = rn;
              d.rt = rt;
            end else begin
              d.opcode = OP_SINGLE;
              d.rt = rt;
              d.rn = rn;
              d.attr.kind = fp ? 2'd2 : 2'd1;
              if (fp && opc[1] && size != 2'd0) st = ST_UNALLOC;
              d.bytes = (fp && size == 2'd0 && opc[1]) ? 5'd16 : (5'd1 << size);
              d.attr.acc = (fp ? opc[0] : (opc != 2'd0)) ? 2'd1 : 2'd2;
              if (!fp && opc != 2'd0) d.attr.ext = opc[1] ? 2'd2 : 2'd1;
              d.attr.xfer = 2'd1;
              d.width = fp ? {d.bytes, 3'b000}
                           : ((size == 2'd3 || opc == 2'd2) ? 8'd64 : 8'd32);
            end
            if (st == ST_OK) begin
              if (d.attr.kind == 2'd1 && size[1] && opc == 2'd3) st = ST_UNALLOC;
              else if (d.attr.kind == 2'd2 && form == 3'd1 && mode == 2'd2)
                st = ST_UNALLOC;
              else if (pf && form == 3'd1 && mode != 2'd0) st = ST_UNALLOC;
            end
            if (st == ST_OK) begin
              if (form == 3'd0) begin
                d.amode = AM_UNSIGNED;
                imm12 = w[21:10];
                case (pf ? 5'd8 : d.bytes)
                  5'd1: scaled = {12'd0, imm12};
                  5'd2: scaled = {11'd0, imm12, 1'b0};
                  5'd4: scaled = {10'd0, imm12, 2'b0};
                  5'd8: scaled = {9'd0, imm12, 3'b0};
                  default: scaled = {8'd0, imm12, 4'b0};
                endcase
                d.off = scaled[20:0];
              end else if (form == 3'd2) begin
                e = w[15:13];
                d.amode = AM_REG;
                d.rsm = rs;
                d.extend = e;
                if (e != 3'd2 && e != 3'd3 && e != 3'd6 && e != 3'd7) begin
                  st = ST_UNALLOC;
                end else if (w[12]) begin
                  if (pf) d.shift = 3'd3;
                  else begin
                    case (d.bytes)
                      5'd1: d.shift = 3'd0;
                      5'd2: d.shift = 3'd1;
                      5'd4: d.shift = 3'd2;
                      5'd8: d.shift = 3'd3;
                      default: d.shift = 3'd4;
                    endcase
                  end
                end
              end else begin
                d.off = sx9(w[20:12]);
                case (mode)
                  2'd1: d.amode = AM_POST;
                  2'd2: d.amode = AM_UNPRIV;
                  2'd3: d.amode = AM_PRE;
                  default: d.amode = AM_UNSCALED;
                endcase
              end
              if (st == ST_OK && d.attr.kind == 2'd1
                  && (d.amode == AM_POST || d.amode == AM_PRE)
                  && rn != 5'd31 && rn == rt) st = ST_UNPRED;
            end
          end
        end
      end
      FAM_UNSUP: begin
        d.opcode = OP_UNKNOWN;
        st = ST_UNSUP;
      end
      default: st = ST_UNALLOC;
    endcase
    if (st == ST_UNALLOC) res_next = '0;
    else res_next = d;
    res_next.status = st;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_result <= res_next;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/arm64_load_store_decoder.sv =====
// AArch64 load/store instruction decoder: front end, queue and back end.
// Depends on lsd_pkg, lsd_front, lsd_queue and lsd_back.
//
// One instruction word enters on the s_axis channel and one decoded result
// leaves on the m_axis channel for each word, in order. The front end
// registers the word with its family class, a queue of Depth entries (two by
// default) follows, and the back end decodes the word into an output
// register. With no stall one item is taken every cycle. When the receiver
// holds m_axis_tready low the output register holds its item, and the queue
// and the front register take up to Depth + 1 more items (three by default)
// before s_axis_tready falls. Synchronous reset empties every stage; the
// block keeps no other state.
`default_nettype none
module arm64_load_store_decoder
  import lsd_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InWidth-1:0]  s_axis_tdata,  // instruction
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // status, opcode, atomic op, access attributes, byte count,
  // register width, addressing mode, offset, extend option, shift,
  // registers, then zero fill
  output logic [OutWidth-1:0]      m_axis_tdata
);
  logic f_valid, f_ready, b_valid, b_ready;
  lsd_item_t f_item, b_item;
  lsd_result_t r;

  lsd_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_word(s_axis_tdata),
    .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
  );

  lsd_queue #(.Depth(Depth)) u_queue (
    .clk(clk), .rst(rst),
    .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
    .out_valid(b_valid), .out_ready(b_ready), .out_item(b_item)
  );

  lsd_back u_back (
    .clk(clk), .rst(rst),
    .in_valid(b_valid), .in_ready(b_ready), .in_item(b_item),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_result(r)
  );

  assign m_axis_tdata = {3'd0, r.rsm, r.rt2, r.rn, r.rt, r.shift, r.extend, r.off,
                         r.amode, r.width, r.bytes,
                         r.attr.xfer, r.attr.ext, r.attr.ord, r.attr.kind, r.attr.acc,
                         r.atop, r.opcode, r.status};
endmodule
`default_nettype wire

// ===== hdl/lsd_checker.sv =====
// Port-level checks of the load/store decoder, bound to its top level.
// Depends on lsd_pkg and arm64_load_store_decoder_assert.svh.
`default_nettype none
`include "arm64_load_store_decoder_assert.svh"
module lsd_checker
  import lsd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [87:0] m_axis_tdata
);
  logic stalled;
  logic [1:0] status;
  logic [3:0] opcode;

  assign stalled = m_axis_tvalid && !m_axis_tready;
  assign status = m_axis_tdata[1:0];
  assign opcode = m_axis_tdata[5:2];

  `LSD_ASSERT_NXT(a_hold, stalled, m_axis_tvalid && $stable(m_axis_tdata), "stalled item changed")
  `LSD_ASSERT_IMP(a_unalloc_zero, m_axis_tvalid && status == ST_UNALLOC, m_axis_tdata[87:2] == '0, "unallocated fields set")
  `LSD_ASSERT_IMP(a_fill_zero, m_axis_tvalid, m_axis_tdata[87:85] == 3'd0, "fill bits set")
  `LSD_ASSERT_IMP(a_opcode_range, m_axis_tvalid, opcode <= OP_SINGLE, "opcode out of range")
endmodule

bind arm64_load_store_decoder lsd_checker u_lsd_checker (
  .clk(clk), .rst(rst),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
